[hw/rtl/tct_pkg.sv]
// Types and constants shared by the TCP connection tracker.
package tct_pkg;

	localparam int CONNECTIONS_DEF = 4;
	localparam int PORT_SLOTS_DEF = 4;
	localparam int WINDOW_BYTES_DEF = 512;
	localparam int CFG_IDX_W = 3;

	localparam logic [7:0] F_FIN = 8'h01;
	localparam logic [7:0] F_SYN = 8'h02;
	localparam logic [7:0] F_RST = 8'h04;
	localparam logic [7:0] F_PSH = 8'h08;
	localparam logic [7:0] F_ACK = 8'h10;

	localparam logic [1:0] ST_CLOSED = 2'd0;
	localparam logic [1:0] ST_SYNRCVD = 2'd1;
	localparam logic [1:0] ST_ESTAB = 2'd2;
	localparam logic [1:0] ST_CLOSEWAIT = 2'd3;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_REPLY = 2'd1;
	localparam logic [1:0] KIND_BUSY = 2'd2;
	localparam logic [1:0] KIND_FULL = 2'd3;

	localparam logic [2:0] REG_PORT_A = 3'd0;
	localparam logic [2:0] REG_PORT_B = 3'd1;
	localparam logic [2:0] REG_PORT_C = 3'd2;
	localparam logic [2:0] REG_PORT_D = 3'd3;
	localparam logic [2:0] REG_MASK = 3'd4;
	localparam logic [2:0] REG_LOCAL = 3'd5;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_WRITE,
		S_SUM,
		S_FOLD,
		S_OUT
	} state_t;

	typedef struct packed {
		logic        mode;
		logic [15:0] dest_port;
		logic [31:0] remote_addr;
		logic [15:0] remote_port;
		logic [7:0]  seg_flags;
		logic [31:0] seg_seq;
		logic [15:0] data_length;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [7:0]  resp_flags;
		logic [15:0] resp_src_port;
		logic [15:0] resp_dst_port;
		logic [31:0] resp_seq;
		logic [31:0] resp_ack;
		logic [15:0] resp_window;
		logic [15:0] resp_checksum;
		logic [1:0]  new_conn_state;
		logic        buffer_ready;
		logic [15:0] buffer_length;
		logic        overrun;
	} out_word_t;

	typedef struct packed {
		logic [1:0]  st;
		logic [15:0] lport;
		logic [31:0] raddr;
		logic [15:0] rport;
		logic [31:0] seq_in;
		logic [31:0] seq_out;
		logic [2:0]  bflags;
		logic [15:0] blen;
	} entry_t;

	// search key shared by every cell of the chain
	typedef struct packed {
		logic [15:0] lport;
		logic [31:0] raddr;
		logic [15:0] rport;
	} key_t;

	typedef struct packed {
		logic found;
		logic free_found;
	} scan_t;

endpackage

[hw/rtl/tcp_connection_tracker_core.sv]
// Top level of the TCP connection tracker: sequencer, step logic and reply checksum.
//  channel | dir | handshake       | word
//  in      | in  | in_valid/in_stall   | in_word_t
//  out     | out | out_valid/out_stall | out_word_t
//  cfg     | in  | cfg_we          | cfg_idx, cfg_data
// One word at a time: the next word is accepted only once the result has been taken.
// The search walks the cell chain one cell a cycle; the checksum is then summed and folded in S_SUM and S_FOLD.
// Reset clears the table, the state and the config registers; no clearing pass.
// in_stall is high from accept until the result is taken; out_stall holds the result.
module tcp_connection_tracker_core
	import tct_pkg::*;
#(
	parameter int CONNECTIONS = CONNECTIONS_DEF,
	parameter int PORT_SLOTS = PORT_SLOTS_DEF,
	parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_word_t             in_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_word_t            out_word
);

	localparam int IDX_W = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
	localparam logic [15:0] WIN = 16'(WINDOW_BYTES);

	state_t st_q, st_d;
	logic [15:0] port_q [4];
	logic [3:0] mask_q;
	logic [31:0] laddr_q;
	in_word_t w_q;
	out_word_t o_q;
	logic [17:0] sum_q;
	logic [31:0] acc_q;
	logic [IDX_W-1:0] k_q;
	logic kv_q;
	logic popen;

	logic start, done;
	scan_t res;
	logic [IDX_W-1:0] hit_idx, free_idx;
	logic wr;
	logic [IDX_W-1:0] wr_idx;
	entry_t wr_data, rd_hit, rd_free;
	key_t key_w;

	// first cell compares in the accept cycle, before w_q is loaded
	always_comb begin
		if (st_q == S_IDLE) begin
			key_w.lport = in_word.dest_port;
			key_w.raddr = in_word.remote_addr;
			key_w.rport = in_word.remote_port;
		end else begin
			key_w.lport = w_q.dest_port;
			key_w.raddr = w_q.remote_addr;
			key_w.rport = w_q.remote_port;
		end
	end

	tct_chain #(.CONNECTIONS(CONNECTIONS), .IDX_W(IDX_W)) u_chain (
		.clk(clk), .arst_n(arst_n), .start(start), .key(key_w),
		.done(done), .res(res), .hit_idx(hit_idx), .free_idx(free_idx),
		.wr(wr), .wr_idx(wr_idx), .wr_data(wr_data), .rd_hit(rd_hit), .rd_free(rd_free)
	);

	always_comb begin
		popen = 1'b0;
		for (int i = PORT_SLOTS - 1; i >= 0; i--) begin
			if (port_q[i] == w_q.dest_port) popen = mask_q[i];
		end
	end

	assign start = st_q == S_IDLE && in_valid;
	assign in_stall = st_q != S_IDLE;
	assign out_valid = st_q == S_OUT;
	assign out_word = o_q;

	always_comb begin
		st_d = st_q;
		case (st_q)
			S_IDLE: if (in_valid) st_d = S_SCAN;
			S_SCAN: if (done) st_d = S_DECIDE;
			S_DECIDE: st_d = S_WRITE;
			S_WRITE: st_d = S_SUM;
			S_SUM: st_d = S_FOLD;
			S_FOLD: st_d = S_OUT;
			S_OUT: if (!out_stall) st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	// step decision, done in S_DECIDE using the chain result
	entry_t e, ne;
	logic [1:0] kind;
	logic [7:0] rfl;
	logic ovr, have, wr_en;
	logic [15:0] room, take;
	logic [16:0] nlen;
	logic [7:0] fl;

	always_comb begin
		fl = w_q.seg_flags;
		have = res.found;
		e = have ? rd_hit : rd_free;
		ne = e;
		kind = KIND_NONE;
		rfl = '0;
		ovr = 1'b0;
		wr_en = 1'b0;
		room = '0;
		take = '0;
		nlen = '0;
		if (w_q.mode) begin
			if (have) begin
				ne.bflags = '0;
				ne.blen = '0;
				wr_en = 1'b1;
			end
		end else if (!popen) begin
			kind = KIND_REPLY;
			rfl = F_RST | F_ACK;
		end else if (fl == F_SYN && !have && !res.free_found) begin
			kind = KIND_FULL;
		end else begin
			// SYN resets a known entry to closed, or takes a free one
			if (fl == F_SYN) begin
				if (!have) begin
					ne.lport = w_q.dest_port;
					ne.raddr = w_q.remote_addr;
					ne.rport = w_q.remote_port;
				end
				ne.st = ST_CLOSED;
				have = 1'b1;
			end
			if (have) begin
				case (ne.st)
					ST_CLOSED: if (fl == F_SYN) begin
						ne.st = ST_SYNRCVD;
						ne.seq_in = w_q.seg_seq + 32'd1;
						ne.seq_out = '0;
						ne.bflags[0] = 1'b0;
						kind = KIND_REPLY;
						rfl = F_SYN | F_ACK;
						wr_en = 1'b1;
					end
					ST_SYNRCVD: if (fl == F_ACK) begin
						ne.st = ST_ESTAB;
						ne.seq_out = ne.seq_out + 32'd1;
						wr_en = 1'b1;
					end
					ST_ESTAB: begin
						if (fl == (F_FIN | F_ACK)) begin
							ne.st = ST_CLOSEWAIT;
							ne.seq_in = ne.seq_in + 32'd1;
							ne.seq_out = ne.seq_out + 32'd1;
							kind = KIND_REPLY;
							rfl = F_FIN | F_ACK;
							wr_en = 1'b1;
						end else if (fl == F_ACK || fl == (F_ACK | F_PSH)) begin
							if (ne.bflags[1:0] == 2'b00) begin
								ne.bflags = 3'b001;
								ne.blen = '0;
							end
							if (!ne.bflags[2] && ne.blen < WIN) begin
								room = WIN - ne.blen;
								take = w_q.data_length;
								if (take > room) begin
									take = room;
									ovr = 1'b1;
								end
								ne.seq_in = ne.seq_in + 32'(take);
								nlen = 17'(ne.blen) + 17'(take);
								ne.blen = nlen[15:0];
								if (ne.blen >= WIN || fl[3]) begin
									ne.bflags[0] = 1'b0;
									ne.bflags[1] = 1'b1;
									kind = KIND_REPLY;
									rfl = F_ACK;
								end
								wr_en = 1'b1;
							end else begin
								kind = KIND_BUSY;
								ne = e;
							end
						end
					end
					default: if (fl == F_ACK) begin
						ne.st = ST_CLOSED;
						wr_en = 1'b1;
					end
				endcase
			end
		end
	end

	entry_t ne_q;
	logic [1:0] kind_q;
	logic [7:0] rfl_q;
	logic ovr_q, wr_q, have_q;

	assign wr = st_q == S_WRITE && wr_q;
	assign wr_idx = k_q;
	assign wr_data = ne_q;

	logic [15:0] win_v;
	logic [31:0] seqv, ackv;
	assign seqv = have_q ? ne_q.seq_out : '0;
	assign ackv = have_q ? ne_q.seq_in : '0;
	assign win_v = (have_q && ne_q.bflags[0]) ? WIN - ne_q.blen : WIN;

	out_word_t o_d;
	logic [16:0] fold;

	always_comb begin
		fold = 17'(sum_q[15:0]) + 17'(sum_q[17:16]);
		o_d = '0;
		o_d.result_kind = kind_q;
		if (kind_q == KIND_REPLY) begin
			o_d.resp_flags = rfl_q;
			o_d.resp_src_port = w_q.dest_port;
			o_d.resp_dst_port = w_q.remote_port;
			o_d.resp_seq = seqv;
			o_d.resp_ack = ackv;
			o_d.resp_window = win_v;
			o_d.resp_checksum = ~(fold[15:0] + 16'(fold[16]));
		end
		if (have_q && kind_q != KIND_FULL) begin
			o_d.new_conn_state = ne_q.st;
			o_d.buffer_ready = ne_q.bflags[1] && !w_q.mode;
			o_d.buffer_length = w_q.mode ? '0 : ne_q.blen;
		end
		o_d.overrun = ovr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			port_q <= '{default: '0};
			mask_q <= '0;
			laddr_q <= '0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				case (cfg_idx)
					REG_PORT_A: port_q[0] <= cfg_data[15:0];
					REG_PORT_B: port_q[1] <= cfg_data[15:0];
					REG_PORT_C: port_q[2] <= cfg_data[15:0];
					REG_PORT_D: port_q[3] <= cfg_data[15:0];
					REG_MASK: mask_q <= cfg_data[3:0];
					REG_LOCAL: laddr_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: if (in_valid) w_q <= in_word;
			S_SCAN: ;
			S_DECIDE: begin
				ne_q <= ne;
				kind_q <= kind;
				rfl_q <= rfl;
				ovr_q <= ovr;
				wr_q <= wr_en;
				// entry seen afterwards: match, or freshly taken slot
				have_q <= have && !(w_q.mode == 1'b0 && !popen && !res.found);
				k_q <= res.found ? hit_idx : free_idx;
				kv_q <= res.found;
			end
			S_WRITE: begin
				acc_q <= 32'(laddr_q[31:16]) + 32'(laddr_q[15:0])
					+ 32'(w_q.remote_addr[31:16]) + 32'(w_q.remote_addr[15:0])
					+ 32'd26 + 32'(w_q.dest_port) + 32'(w_q.remote_port)
					+ 32'(seqv[31:16]) + 32'(seqv[15:0]) + 32'(ackv[31:16])
					+ 32'(ackv[15:0]) + 32'({8'h50, rfl_q}) + 32'(win_v);
			end
			S_SUM: sum_q <= 18'(acc_q[15:0]) + 18'(acc_q[31:16]);
			S_FOLD: o_q <= o_d;
			default: ;
		endcase
	end

	a_kv: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_WRITE && wr_q |-> kv_q || have_q)
		else $error("write without entry");
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("result dropped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");

endmodule

[hw/rtl/tct_cell.sv]
// One connection table entry: holds its state and matches the key shared by all cells of the chain.
module tct_cell
	import tct_pkg::*;
#(
	parameter int IDX_W = 2,
	parameter logic [IDX_W-1:0] MY_IDX = '0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             scan,
	input  key_t             key,
	input  scan_t            scan_in,
	input  logic [IDX_W-1:0] hit_idx_in,
	input  logic [IDX_W-1:0] free_idx_in,
	output scan_t            scan_out,
	output logic [IDX_W-1:0] hit_idx_out,
	output logic [IDX_W-1:0] free_idx_out,
	input  logic             wr,
	input  logic [IDX_W-1:0] wr_idx,
	input  entry_t           wr_data,
	output entry_t           entry
);

	entry_t entry_q;
	logic match;

	assign entry = entry_q;
	assign match = scan && entry_q.lport == key.lport && entry_q.raddr == key.raddr
		&& entry_q.rport == key.rport;

	always_comb begin
		scan_out = scan_in;
		hit_idx_out = hit_idx_in;
		free_idx_out = free_idx_in;
		if (!scan_in.found && match) begin
			scan_out.found = 1'b1;
			hit_idx_out = MY_IDX;
		end
		if (!scan_in.free_found && scan && entry_q.st == ST_CLOSED) begin
			scan_out.free_found = 1'b1;
			free_idx_out = MY_IDX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (wr && wr_idx == MY_IDX) begin
			entry_q <= wr_data;
		end
	end

endmodule

[hw/rtl/tct_chain.sv]
// Row of table cells; the search result ripples through a register after each cell.
module tct_chain
	import tct_pkg::*;
#(
	parameter int CONNECTIONS = CONNECTIONS_DEF,
	parameter int IDX_W = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  key_t             key,
	output logic             done,
	output scan_t            res,
	output logic [IDX_W-1:0] hit_idx,
	output logic [IDX_W-1:0] free_idx,
	input  logic             wr,
	input  logic [IDX_W-1:0] wr_idx,
	input  entry_t           wr_data,
	output entry_t           rd_hit,
	output entry_t           rd_free
);

	scan_t            sc_q [CONNECTIONS+1];
	logic [IDX_W-1:0] hi_q [CONNECTIONS+1];
	logic [IDX_W-1:0] fi_q [CONNECTIONS+1];
	logic             v_q  [CONNECTIONS+1];
	entry_t           ent  [CONNECTIONS];
	scan_t            res_q;
	logic [IDX_W-1:0] hit_q, free_q;

	always_comb begin
		sc_q[0] = '0;
		hi_q[0] = '0;
		fi_q[0] = '0;
		v_q[0] = start;
	end

	for (genvar i = 0; i < CONNECTIONS; i++) begin : g_cell
		scan_t            so;
		logic [IDX_W-1:0] ho, fo;
		scan_t            sr_q;
		logic [IDX_W-1:0] hr_q, fr_q;
		logic             vr_q;
		tct_cell #(.IDX_W(IDX_W), .MY_IDX(IDX_W'(i))) u_cell (
			.clk(clk), .arst_n(arst_n), .scan(v_q[i]), .key(key),
			.scan_in(sc_q[i]), .hit_idx_in(hi_q[i]), .free_idx_in(fi_q[i]),
			.scan_out(so), .hit_idx_out(ho), .free_idx_out(fo),
			.wr(wr), .wr_idx(wr_idx), .wr_data(wr_data), .entry(ent[i])
		);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vr_q <= 1'b0;
			end else begin
				vr_q <= v_q[i];
			end
		end
		always_ff @(posedge clk) begin
			sr_q <= so;
			hr_q <= ho;
			fr_q <= fo;
		end
		always_comb begin
			sc_q[i+1] = sr_q;
			hi_q[i+1] = hr_q;
			fi_q[i+1] = fr_q;
			v_q[i+1] = vr_q;
		end
	end

	// hold the search result once it leaves the last cell
	always_ff @(posedge clk) begin
		if (v_q[CONNECTIONS]) begin
			res_q <= sc_q[CONNECTIONS];
			hit_q <= hi_q[CONNECTIONS];
			free_q <= fi_q[CONNECTIONS];
		end
	end

	assign done = v_q[CONNECTIONS];
	assign res = res_q;
	assign hit_idx = hit_q;
	assign free_idx = free_q;
	assign rd_hit = ent[hit_q];
	assign rd_free = ent[free_q];

endmodule

[tb/sv/tcp_connection_tracker_core_checker.sv]
// Checker for the TCP connection tracker: mirrors the connection table and compares every result.
module tcp_connection_tracker_core_checker
	import tct_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  in_word_t             in_word,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  out_word_t            out_word,
	output int                   errors,
	output int                   pending
);

	localparam int NCONN = CONNECTIONS_DEF;
	localparam int WIN = WINDOW_BYTES_DEF;

	logic [15:0] listen_port [4];
	logic [3:0]  listen_mask;
	logic [31:0] own_addr;
	entry_t      conn [NCONN];
	out_word_t   expected_words [$];

	function automatic bit port_listening(logic [15:0] p);
		for (int i = 0; i < PORT_SLOTS_DEF && i < 4; i++)
			if (listen_port[i] == p)
				return listen_mask[i];
		return 1'b0;
	endfunction

	function automatic int lookup_conn(logic [15:0] lp, logic [31:0] ra, logic [15:0] rp);
		for (int i = 0; i < NCONN; i++)
			if (conn[i].lport == lp && conn[i].raddr == ra && conn[i].rport == rp)
				return i;
		return -1;
	endfunction

	function automatic logic [15:0] header_sum(logic [31:0] ra, logic [15:0] sp,
			logic [15:0] dp, logic [31:0] sq, logic [31:0] ak, logic [7:0] fl,
			logic [15:0] win);
		logic [31:0] s;
		s = own_addr[31:16] + own_addr[15:0] + ra[31:16] + ra[15:0] + 32'd26
			+ sp + dp + sq[31:16] + sq[15:0] + ak[31:16] + ak[15:0]
			+ (32'h5000 | fl) + win;
		while (s[31:16] != 0)
			s = s[15:0] + s[31:16];
		return ~s[15:0];
	endfunction

	function automatic out_word_t track_segment(in_word_t w);
		out_word_t r;
		logic [1:0] kind;
		logic [7:0] rf;
		logic ovr;
		int k;
		logic [1:0] st;
		logic [31:0] room, take, sq, ak;
		logic [15:0] win;
		r = '0;
		kind = KIND_NONE;
		rf = 8'h00;
		ovr = 1'b0;
		if (w.mode) begin
			k = lookup_conn(w.dest_port, w.remote_addr, w.remote_port);
			if (k >= 0) begin
				conn[k].bflags = 3'b000;
				conn[k].blen = 16'd0;
				r.new_conn_state = conn[k].st;
			end
			return r;
		end
		if (!port_listening(w.dest_port)) begin
			kind = KIND_REPLY;
			rf = F_RST | F_ACK;
		end else begin
			if (w.seg_flags == F_SYN) begin
				k = lookup_conn(w.dest_port, w.remote_addr, w.remote_port);
				if (k < 0) begin
					for (int i = 0; i < NCONN; i++)
						if (conn[i].st == ST_CLOSED) begin
							k = i;
							break;
						end
					if (k < 0) begin
						r.result_kind = KIND_FULL;
						return r;
					end
					conn[k].lport = w.dest_port;
					conn[k].raddr = w.remote_addr;
					conn[k].rport = w.remote_port;
				end
				conn[k].st = ST_CLOSED;
			end
			k = lookup_conn(w.dest_port, w.remote_addr, w.remote_port);
			st = (k >= 0) ? conn[k].st : ST_CLOSED;
			case (st)
				ST_CLOSED: begin
					if (w.seg_flags == F_SYN && k >= 0) begin
						conn[k].st = ST_SYNRCVD;
						conn[k].seq_in = w.seg_seq + 32'd1;
						conn[k].seq_out = 32'd0;
						conn[k].bflags[0] = 1'b0;
						kind = KIND_REPLY;
						rf = F_SYN | F_ACK;
					end
				end
				ST_SYNRCVD: begin
					if (w.seg_flags == F_ACK) begin
						conn[k].st = ST_ESTAB;
						conn[k].seq_out += 1;
					end
				end
				ST_ESTAB: begin
					if (w.seg_flags == (F_FIN | F_ACK)) begin
						conn[k].st = ST_CLOSEWAIT;
						conn[k].seq_in += 1;
						conn[k].seq_out += 1;
						kind = KIND_REPLY;
						rf = F_FIN | F_ACK;
					end else if (w.seg_flags == F_ACK || w.seg_flags == (F_ACK | F_PSH)) begin
						if (conn[k].bflags[1:0] == 2'b00) begin
							conn[k].bflags = 3'b001;
							conn[k].blen = 16'd0;
						end
						if (!conn[k].bflags[2] && conn[k].blen < WIN) begin
							room = 32'(WIN) - 32'(conn[k].blen);
							take = 32'(w.data_length);
							if (take > room) begin
								take = room;
								ovr = 1'b1;
							end
							conn[k].seq_in += take;
							conn[k].blen = conn[k].blen + take[15:0];
							if (conn[k].blen >= WIN || (w.seg_flags & F_PSH) != 0) begin
								conn[k].bflags[0] = 1'b0;
								conn[k].bflags[1] = 1'b1;
								kind = KIND_REPLY;
								rf = F_ACK;
							end
						end else begin
							kind = KIND_BUSY;
						end
					end
				end
				default: begin
					if (w.seg_flags == F_ACK)
						conn[k].st = ST_CLOSED;
				end
			endcase
		end
		k = lookup_conn(w.dest_port, w.remote_addr, w.remote_port);
		if (kind == KIND_REPLY) begin
			sq = 32'd0;
			ak = 32'd0;
			win = 16'(WIN);
			if (k >= 0) begin
				sq = conn[k].seq_out;
				ak = conn[k].seq_in;
				if (conn[k].bflags[0])
					win = 16'(WIN) - conn[k].blen;
			end
			r.resp_flags = rf;
			r.resp_src_port = w.dest_port;
			r.resp_dst_port = w.remote_port;
			r.resp_seq = sq;
			r.resp_ack = ak;
			r.resp_window = win;
			r.resp_checksum = header_sum(w.remote_addr, w.dest_port, w.remote_port,
				sq, ak, rf, win);
		end
		r.result_kind = kind;
		if (k >= 0) begin
			r.new_conn_state = conn[k].st;
			r.buffer_ready = conn[k].bflags[1];
			r.buffer_length = conn[k].blen;
		end
		r.overrun = ovr;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("result %s: got %0h, expected %0h", what, got, want);
		errors++;
	endtask

	assign pending = expected_words.size();

	always @(posedge clk or negedge arst_n) begin
		out_word_t e;
		if (!arst_n) begin
			errors = 0;
			expected_words.delete();
			listen_mask = '0;
			own_addr = '0;
			for (int i = 0; i < 4; i++)
				listen_port[i] = '0;
			for (int i = 0; i < NCONN; i++)
				conn[i] = '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_PORT_A, REG_PORT_B, REG_PORT_C, REG_PORT_D:
						listen_port[cfg_idx[1:0]] = cfg_data[15:0];
					REG_MASK: listen_mask = cfg_data[3:0];
					REG_LOCAL: own_addr = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					report_mismatch("unexpected word", 32'(out_word.result_kind), 32'd0);
				end else begin
					e = expected_words.pop_front();
					if (out_word.result_kind !== e.result_kind)
						report_mismatch("result_kind", out_word.result_kind, e.result_kind);
					if (out_word.resp_flags !== e.resp_flags)
						report_mismatch("resp_flags", out_word.resp_flags, e.resp_flags);
					if (out_word.resp_src_port !== e.resp_src_port)
						report_mismatch("resp_src_port", out_word.resp_src_port,
							e.resp_src_port);
					if (out_word.resp_dst_port !== e.resp_dst_port)
						report_mismatch("resp_dst_port", out_word.resp_dst_port,
							e.resp_dst_port);
					if (out_word.resp_seq !== e.resp_seq)
						report_mismatch("resp_seq", out_word.resp_seq, e.resp_seq);
					if (out_word.resp_ack !== e.resp_ack)
						report_mismatch("resp_ack", out_word.resp_ack, e.resp_ack);
					if (out_word.resp_window !== e.resp_window)
						report_mismatch("resp_window", out_word.resp_window, e.resp_window);
					if (out_word.resp_checksum !== e.resp_checksum)
						report_mismatch("resp_checksum", out_word.resp_checksum,
							e.resp_checksum);
					if (out_word.new_conn_state !== e.new_conn_state)
						report_mismatch("new_conn_state", out_word.new_conn_state,
							e.new_conn_state);
					if (out_word.buffer_ready !== e.buffer_ready)
						report_mismatch("buffer_ready", out_word.buffer_ready, e.buffer_ready);
					if (out_word.buffer_length !== e.buffer_length)
						report_mismatch("buffer_length", out_word.buffer_length,
							e.buffer_length);
					if (out_word.overrun !== e.overrun)
						report_mismatch("overrun", out_word.overrun, e.overrun);
				end
			end
			if (in_valid && !in_stall)
				expected_words.push_back(track_segment(in_word));
		end
	end

endmodule

[tb/sv/tcp_connection_tracker_core_test.sv]
// Testbench top for the TCP connection tracker: stimulus, idling phases and verdict.
module tcp_connection_tracker_core_test;
	import tct_pkg::*;

	localparam int LIMIT = 400000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [31:0]          cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	in_word_t             in_word;
	logic                 out_valid;
	logic                 out_stall;
	out_word_t            out_word;
	int                   errors;
	int                   pending;
	int                   cycles = 0;
	int                   send_idle_pct;
	int                   stall_pct;
	logic [15:0]          ports [4];
	logic [31:0]          peer_addr [3];

	tcp_connection_tracker_core i_dut (.*);

	tcp_connection_tracker_core_checker i_checker (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tcp_connection_tracker_core: mismatch");
			$finish;
		end
	end

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_segment(logic m, logic [15:0] dp, logic [31:0] ra, logic [15:0] rp,
			logic [7:0] fl, logic [31:0] sq, logic [15:0] dl);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct)
			@(negedge clk);
		in_valid <= 1'b1;
		in_word <= '{m, dp, ra, rp, fl, sq, dl};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic drain_and_configure(logic [15:0] pa, logic [15:0] pb, logic [15:0] pc,
			logic [15:0] pd, logic [3:0] mask, logic [31:0] la);
		while (pending != 0)
			@(negedge clk);
		repeat (20)
			@(negedge clk);
		ports = '{pa, pb, pc, pd};
		write_reg(REG_PORT_A, 32'(pa));
		write_reg(REG_PORT_B, 32'(pb));
		write_reg(REG_PORT_C, 32'(pc));
		write_reg(REG_PORT_D, 32'(pd));
		write_reg(REG_MASK, 32'(mask));
		write_reg(REG_LOCAL, la);
	endtask

	task automatic random_segment();
		logic [15:0] dp, rp;
		logic [31:0] ra;
		logic [7:0]  fl;
		int c;
		dp = ($urandom_range(9) == 0) ? 16'($urandom) : ports[2'($urandom_range(3))];
		ra = ($urandom_range(15) == 0) ? $urandom : peer_addr[2'($urandom_range(2))];
		rp = ($urandom_range(15) == 0) ? 16'($urandom) : 16'($urandom_range(1, 3));
		c = $urandom_range(99);
		if (c < 20) fl = F_SYN;
		else if (c < 45) fl = F_ACK;
		else if (c < 70) fl = F_ACK | F_PSH;
		else if (c < 80) fl = F_FIN | F_ACK;
		else fl = 8'($urandom);
		send_segment($urandom_range(9) == 0, dp, ra, rp, fl, $urandom,
			($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(300)));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_word = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		ports = '{16'd0, 16'd0, 16'd0, 16'd0};
		peer_addr = '{32'h0A000001, 32'hFFFFFFFF, 32'h00000000};
		repeat (9)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset config: port 0 matches slot 0 but closed
		send_segment(1'b0, 16'd0, 32'h0, 16'd0, F_SYN, 32'h0, 16'd0);
		drain_and_configure(16'd80, 16'd80, 16'hFFFF, 16'd443, 4'b1101, 32'hC0A80001);
		// full handshake, data with overrun, push, busy, release, close
		send_segment(1'b0, 16'd80, 32'hFFFFFFFF, 16'hFFFF, F_SYN, 32'hFFFFFFFF, 16'd0);
		send_segment(1'b0, 16'd80, 32'hFFFFFFFF, 16'hFFFF, F_ACK, 32'h0, 16'd0);
		send_segment(1'b0, 16'd80, 32'hFFFFFFFF, 16'hFFFF, F_ACK, 32'h1, 16'd100);
		send_segment(1'b0, 16'd80, 32'hFFFFFFFF, 16'hFFFF, F_ACK, 32'h1, 16'hFFFF);
		send_segment(1'b0, 16'd80, 32'hFFFFFFFF, 16'hFFFF, F_ACK | F_PSH, 32'h1, 16'd5);
		send_segment(1'b1, 16'd80, 32'hFFFFFFFF, 16'hFFFF, 8'h00, 32'h0, 16'd0);
		send_segment(1'b0, 16'd80, 32'hFFFFFFFF, 16'hFFFF, F_ACK | F_PSH, 32'h1, 16'd7);
		send_segment(1'b0, 16'd80, 32'hFFFFFFFF, 16'hFFFF, 8'hFF, 32'h1, 16'd7);
		send_segment(1'b0, 16'd80, 32'hFFFFFFFF, 16'hFFFF, F_FIN | F_ACK, 32'h1, 16'd0);
		send_segment(1'b0, 16'd80, 32'hFFFFFFFF, 16'hFFFF, F_ACK, 32'h1, 16'd0);
		// unused release, SYN to the open port in slot 2, unknown port
		send_segment(1'b1, 16'd1, 32'h1, 16'd1, 8'h00, 32'h0, 16'd0);
		send_segment(1'b0, 16'hFFFF, 32'h12345678, 16'd9, F_SYN, 32'h0, 16'd0);
		send_segment(1'b0, 16'd7, 32'h12345678, 16'd9, F_ACK, 32'h0, 16'd0);
		// fill table, then table full
		for (int i = 0; i < 5; i++)
			send_segment(1'b0, 16'd443, 32'h0A000002, 16'(i + 10), F_SYN, 32'h100, 16'd0);
		send_segment(1'b0, 16'd443, 32'h0A000002, 16'd11, F_SYN, 32'h200, 16'd0);

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: drain_and_configure(16'd1, 16'd2, 16'd3, 16'd4, 4'hF, 32'hFFFFFFFF);
				1: drain_and_configure(16'd1, 16'd2, 16'd3, 16'd4, 4'h0, 32'h00000000);
				2: drain_and_configure(16'd1, 16'd2, 16'd3, 16'd4, 4'hF, 32'($urandom));
				default: drain_and_configure(16'($urandom), 16'd2, 16'd3, 16'($urandom),
					4'($urandom), $urandom);
			endcase
			case (ph % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 49; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 49; end
				default: begin send_idle_pct = 16; stall_pct = 16; end
			endcase
			for (int n = 0; n < 185; n++) begin
				if (n % 40 == 0)
					for (int c = 0; c < 4; c++)
						send_segment(1'b1, ports[2'($urandom_range(3))],
							peer_addr[2'($urandom_range(2))], 16'($urandom_range(1, 3)),
							8'h00, 32'h0, 16'd0);
				random_segment();
			end
		end

		while (pending != 0)
			@(negedge clk);
		repeat (30)
			@(negedge clk);
		if (errors == 0)
			$display("tcp_connection_tracker_core: match");
		else
			$display("tcp_connection_tracker_core: mismatch");
		$finish;
	end

endmodule
